### src/packed_table_base64_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packed table base64url encoder
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef PACKED_TABLE_BASE64_ENCODER_CORE_DEFINES_SVH
`define PACKED_TABLE_BASE64_ENCODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTBE_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptbe: implication check failed");

// The expression must never be true.
`define PTBE_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ptbe: forbidden condition seen");

`endif

### src/ptbe_pkg.sv
// ----------------------------------------------------------------------------
// ptbe_pkg
// Shared constants, types and the base64url character map.
// ----------------------------------------------------------------------------
package ptbe_pkg;

    localparam int GROUP_BITS         = 6;
    localparam int MAX_FIELD_BITS_DEF = 7;
    localparam int FIFO_DEPTH_DEF     = 2;
    localparam int DOMAIN_W           = 7;
    localparam int CHAR_W             = 7;
    localparam int TDATA_W            = 8;

    localparam logic [DOMAIN_W-1:0] DOMAIN_RESET = 7'd1;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_UNDER   = 7'd95;

    localparam logic [GROUP_BITS-1:0] GRP_LOWER_BASE = 6'd26;
    localparam logic [GROUP_BITS-1:0] GRP_DIGIT_BASE = 6'd52;
    localparam logic [GROUP_BITS-1:0] GRP_DASH       = 6'd62;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [GROUP_BITS-1:0] g);
        logic [CHAR_W-1:0] gx;
        gx = CHAR_W'(g);
        if (g < GRP_LOWER_BASE)
            return CHAR_UPPER_A + gx;
        else if (g < GRP_DIGIT_BASE)
            return CHAR_LOWER_A + gx - CHAR_W'(GRP_LOWER_BASE);
        else if (g < GRP_DASH)
            return CHAR_DIGIT_0 + gx - CHAR_W'(GRP_DIGIT_BASE);
        else if (g == GRP_DASH)
            return CHAR_DASH;
        else
            return CHAR_UNDER;
    endfunction

endpackage

### src/ptbe_front.sv
// ----------------------------------------------------------------------------
// ptbe_front
// Holds the domain size and packs each accepted entry into a field.
// ----------------------------------------------------------------------------
module ptbe_front #(
    parameter int MAX_FIELD_BITS = ptbe_pkg::MAX_FIELD_BITS_DEF,
    parameter int WCNT_W         = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptbe_pkg::DOMAIN_W-1:0] cfg_wdata,
    input  logic [ptbe_pkg::DOMAIN_W-1:0] entry_value,
    output logic [MAX_FIELD_BITS-1:0]     field,
    output logic [WCNT_W-1:0]             field_width
);
    import ptbe_pkg::*;

    logic [DOMAIN_W-1:0]       domain_size_reg;
    logic [DOMAIN_W-1:0]       domain_size_next;
    logic [MAX_FIELD_BITS-1:0] width_mask;

    // Width is one plus the index of the top set bit, a zero domain counts as one.
    function automatic logic [WCNT_W-1:0] calc_width(input logic [DOMAIN_W-1:0] d);
        int w;
        w = 1;
        for (int i = 1; i < DOMAIN_W; i++)
        begin
            if (d[i])
                w = i + 1;
        end
        if (w > MAX_FIELD_BITS)
            w = MAX_FIELD_BITS;
        return WCNT_W'(w);
    endfunction

    always_comb
    begin
        domain_size_next = cfg_we ? cfg_wdata : domain_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            domain_size_reg <= DOMAIN_RESET;
        else
            domain_size_reg <= domain_size_next;
    end

    always_comb
    begin
        field_width = calc_width(domain_size_reg);
        width_mask  = (MAX_FIELD_BITS'(1) << field_width) - MAX_FIELD_BITS'(1);
        // pack no-action entries as all ones
        if (entry_value < domain_size_reg)
            field = MAX_FIELD_BITS'(entry_value) & width_mask;
        else
            field = width_mask;
    end

endmodule

### src/ptbe_fifo.sv
// ----------------------------------------------------------------------------
// ptbe_fifo
// Short register queue between the packing front and the emitting back.
// ----------------------------------------------------------------------------
module ptbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ptbe_pkg::FIFO_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output ptbe_pkg::fifo_status_t status
);
    import ptbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

### src/ptbe_back.sv
// ----------------------------------------------------------------------------
// ptbe_back
// Bit accumulator and character emitter, one character per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ptbe_back #(
    parameter int MAX_FIELD_BITS = ptbe_pkg::MAX_FIELD_BITS_DEF,
    parameter int WCNT_W         = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entry_valid,
    input  logic [MAX_FIELD_BITS-1:0]    entry_field,
    input  logic [WCNT_W-1:0]            entry_width,
    input  logic                         entry_last,
    output logic                         pop,
    output logic                         idle,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ptbe_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import ptbe_pkg::*;

    localparam int ACC_W  = GROUP_BITS - 1 + MAX_FIELD_BITS;
    localparam int PEND_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic                  slot_free;
    logic                  load;
    logic [GROUP_BITS-1:0] grp;
    logic                  grp_last;
    logic [ACC_W-1:0]      merged;
    logic [PEND_W-1:0]     total;
    logic [PEND_W-1:0]     rem;

    function automatic logic [GROUP_BITS-1:0] pad_mask(input logic [PEND_W-1:0] n);
        return ~GROUP_BITS'((ACC_W'(1) << n) - ACC_W'(1));
    endfunction

    always_comb
    begin
        slot_free = !out_valid_reg || m_tready;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        fin_next  = fin_reg;
        pop       = 1'b0;
        load      = 1'b0;
        grp       = '0;
        grp_last  = 1'b0;
        merged    = acc_reg | (ACC_W'(entry_field) << pend_reg);
        total     = pend_reg + PEND_W'(entry_width);
        rem       = '0;
        if (slot_free)
        begin
            if (pend_reg >= PEND_W'(GROUP_BITS))
            begin
                // drain a full group left from the previous entry
                load      = 1'b1;
                grp       = acc_reg[GROUP_BITS-1:0];
                rem       = pend_reg - PEND_W'(GROUP_BITS);
                grp_last  = fin_reg && (rem == '0);
                acc_next  = acc_reg >> GROUP_BITS;
                pend_next = rem;
                if (grp_last)
                    fin_next = 1'b0;
            end
            else if (fin_reg)
            begin
                load      = 1'b1;
                grp       = acc_reg[GROUP_BITS-1:0] | pad_mask(pend_reg);
                grp_last  = 1'b1;
                acc_next  = '0;
                pend_next = '0;
                fin_next  = 1'b0;
            end
            else if (entry_valid)
            begin
                pop = 1'b1;
                if (total >= PEND_W'(GROUP_BITS))
                begin
                    load      = 1'b1;
                    grp       = merged[GROUP_BITS-1:0];
                    rem       = total - PEND_W'(GROUP_BITS);
                    grp_last  = entry_last && (rem == '0);
                    acc_next  = merged >> GROUP_BITS;
                    pend_next = rem;
                    fin_next  = entry_last && (rem != '0);
                end
                else if (entry_last)
                begin
                    load      = 1'b1;
                    grp       = merged[GROUP_BITS-1:0] | pad_mask(total);
                    grp_last  = 1'b1;
                    acc_next  = '0;
                    pend_next = '0;
                end
                else
                begin
                    acc_next  = merged;
                    pend_next = total;
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = b64_char(grp);
            out_last_next  = grp_last;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign idle     = (pend_reg == '0) && !fin_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - CHAR_W)'(0), out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

### src/packed_table_base64_encoder_core.sv
// ----------------------------------------------------------------------------
// packed_table_base64_encoder_core
// Packs table entries into a bit stream and emits it as base64url text.
// ----------------------------------------------------------------------------
// Input stream s_*: one table entry per transaction, s_tlast on the final
// entry of a table. Output stream m_*: one ASCII character per transaction,
// m_tlast on the final character of the text.
// cfg_we/cfg_wdata write the domain size; write it only while the block is
// idle. Entries at or above the domain size pack as all ones.
// An entry passes through the entry queue and then the output register
// before its first character, if it yields one, is on m_tdata. The output
// register moves one character per cycle while the receiver is ready; while
// the second character of an entry drains, the next entry waits in the queue.
// Reset clears the bit accumulator, empties the entry queue and sets the
// domain size to one.
// When the receiver stalls, the character holds in the output register,
// the entry queue fills and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module packed_table_base64_encoder_core #(
    parameter int MAX_FIELD_BITS = ptbe_pkg::MAX_FIELD_BITS_DEF,
    parameter int FIFO_DEPTH     = ptbe_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptbe_pkg::DOMAIN_W-1:0] cfg_wdata,   // domain_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptbe_pkg::TDATA_W-1:0]  s_tdata,     // [6:0] entry_value, [7] zero
    input  logic                          s_tlast,     // last_entry
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptbe_pkg::TDATA_W-1:0]  m_tdata,     // [6:0] out_char, [7] zero
    output logic                          m_tlast      // last_char
);
    import ptbe_pkg::*;

    localparam int WCNT_W = $clog2(MAX_FIELD_BITS + 1);
    localparam int QW     = MAX_FIELD_BITS + WCNT_W + 1;

    logic [MAX_FIELD_BITS-1:0] front_field;
    logic [WCNT_W-1:0]         front_width;
    logic                      push;
    logic                      pop;
    logic [QW-1:0]             q_din;
    logic [QW-1:0]             q_dout;
    fifo_status_t              q_status;
    logic                      back_idle;

    ptbe_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .WCNT_W         (WCNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_value (s_tdata[DOMAIN_W-1:0]),
        .field       (front_field),
        .field_width (front_width)
    );

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;
    assign q_din    = {s_tlast, front_width, front_field};

    ptbe_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_din),
        .pop       (pop),
        .pop_data  (q_dout),
        .status    (q_status)
    );

    ptbe_back #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .WCNT_W         (WCNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (!q_status.empty),
        .entry_field (q_dout[MAX_FIELD_BITS-1:0]),
        .entry_width (q_dout[MAX_FIELD_BITS+WCNT_W-1:MAX_FIELD_BITS]),
        .entry_last  (q_dout[QW-1]),
        .pop         (pop),
        .idle        (back_idle),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`include "packed_table_base64_encoder_core_defines.svh"

    `PTBE_ASSERT_NEVER(a_pop_when_empty, pop && q_status.empty)
    `PTBE_ASSERT_NEVER(a_push_when_full, push && q_status.full)
    `PTBE_ASSERT_IMPLIES(a_final_char_clears_acc, m_tvalid && m_tlast, back_idle)

endmodule
